// File: rtl/core/sdsk_pkg.sv
// ----------------------------------------------------------------------------
// sdsk_pkg
// Beat types, register codes and binary32 helper functions shared by the
// depth sort key pipeline.
// ----------------------------------------------------------------------------
package sdsk_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RANGE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKETS   = 3'd5;

    localparam logic       ACT_POINT = 1'b0;
    localparam logic       ACT_TABLE = 1'b1;
    localparam logic [31:0] KEY_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] FP_QNAN  = 32'h7FC0_0000;

    typedef struct packed {
        logic        action;
        logic [31:0] center_x;
        logic [31:0] center_y;
        logic [31:0] center_z;
        logic        last_point;
        logic [4:0]  table_index;
        logic [30:0] entry_base;
        logic [23:0] entry_divider;
    } in_beat_t;

    typedef struct packed {
        logic [30:0] sort_key;
        logic        last_key;
    } out_beat_t;

    // Fields that ride alongside the arithmetic through the pipeline.
    typedef struct packed {
        logic        valid;
        logic        action;
        logic        last_point;
        logic [4:0]  table_index;
        logic [30:0] entry_base;
        logic [23:0] entry_divider;
    } side_t;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) n = 6'(47 - i);
        end
        return n;
    endfunction

    // Rounds a significand with its leading one at bit 47 to nearest even,
    // denormalising first when the exponent has fallen below the normal range.
    function automatic logic [31:0] fp_round_pack(input logic sgn,
                                                  input logic signed [10:0] er,
                                                  input logic [47:0] sig);
        logic [47:0] s;
        logic [47:0] mask;
        logic [5:0]  sh;
        logic        st;
        logic [7:0]  ef;
        logic        inc;
        logic [30:0] mag;
        s  = sig;
        ef = er[7:0];
        if (er >= 11'sd255) return {sgn, 8'hFF, 23'd0};
        if (er <= 11'sd0) begin
            sh   = (er < -11'sd47) ? 6'd48 : 6'(11'sd1 - er);
            mask = ~(48'hFFFF_FFFF_FFFF << sh);
            st   = |(s & mask);
            s    = (s >> sh) | {47'd0, st};
            ef   = 8'd0;
        end
        inc = s[23] & ((|s[22:0]) | s[24]);
        mag = {ef, s[46:24]} + 31'(inc);
        return {sgn, mag};
    endfunction

    function automatic logic fp_is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic fp_is_inf(input logic [31:0] a);
        return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    endfunction

    function automatic logic signed [10:0] fp_exp(input logic [31:0] a);
        return (a[30:23] == 8'd0) ? 11'sd1 : $signed({3'b000, a[30:23]});
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic              sgn;
        logic              a_zero;
        logic              b_zero;
        logic [23:0]       ma;
        logic [23:0]       mb;
        logic [47:0]       p;
        logic [5:0]        lz;
        logic signed [10:0] er;
        sgn    = a[31] ^ b[31];
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        if (fp_is_nan(a) || fp_is_nan(b) || (fp_is_inf(a) && b_zero) ||
            (fp_is_inf(b) && a_zero)) return FP_QNAN;
        if (fp_is_inf(a) || fp_is_inf(b)) return {sgn, 8'hFF, 23'd0};
        if (a_zero || b_zero) return {sgn, 31'd0};
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        p  = ma * mb;
        lz = lzc48(p);
        er = fp_exp(a) + fp_exp(b) - 11'sd126 - $signed({5'd0, lz});
        return fp_round_pack(sgn, er, p << lz);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]       x;
        logic [31:0]       y;
        logic signed [10:0] ex;
        logic signed [10:0] dsh;
        logic [5:0]        sh;
        logic [47:0]       ax;
        logic [47:0]       by;
        logic [47:0]       mask;
        logic [47:0]       sum;
        logic [5:0]        lz;
        logic              st;
        if (fp_is_nan(a) || fp_is_nan(b)) return FP_QNAN;
        if (fp_is_inf(a) && fp_is_inf(b)) return (a[31] != b[31]) ? FP_QNAN : a;
        if (fp_is_inf(a)) return a;
        if (fp_is_inf(b)) return b;
        if (a[30:0] >= b[30:0]) begin
            x = a;
            y = b;
        end else begin
            x = b;
            y = a;
        end
        ex   = fp_exp(x);
        dsh  = ex - fp_exp(y);
        sh   = (dsh > 11'sd48) ? 6'd48 : 6'(dsh);
        ax   = {1'b0, x[30:23] != 8'd0, x[22:0], 23'd0};
        by   = {1'b0, y[30:23] != 8'd0, y[22:0], 23'd0};
        mask = ~(48'hFFFF_FFFF_FFFF << sh);
        st   = |(by & mask);
        by   = (by >> sh) | {47'd0, st};
        sum  = (x[31] ^ y[31]) ? (ax - by) : (ax + by);
        // An exact zero is positive unless both operands were negative.
        if (sum == 48'd0) return {x[31] & y[31], 31'd0};
        lz = lzc48(sum);
        return fp_round_pack(x[31], ex + 11'sd1 - $signed({5'd0, lz}), sum << lz);
    endfunction

    // Truncates a non-negative binary32 value below 2^25 to an integer.
    function automatic logic [24:0] fp_to_uint(input logic [31:0] f);
        logic [24:0] m;
        m = {1'b0, 1'b1, f[22:0]};
        if (f[30:23] < 8'd127) return 25'd0;
        if (f[30:23] >= 8'd150) return m << (f[30:23] - 8'd150);
        return m >> (8'd150 - f[30:23]);
    endfunction

    function automatic logic [31:0] uint_to_fp(input logic [23:0] v);
        logic [4:0]  lz;
        logic [23:0] n;
        lz = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) lz = 5'(23 - i);
        end
        n = v << lz;
        if (v == 24'd0) return 32'd0;
        return {1'b0, 8'(8'd150 - {3'd0, lz}), n[22:0]};
    endfunction

endpackage

// File: rtl/core/sdsk_depth.sv
// ----------------------------------------------------------------------------
// sdsk_depth
// Five stage binary32 datapath: three projections, two sums, the offset
// subtraction and the scale into bin units.
// ----------------------------------------------------------------------------
module sdsk_depth (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  sdsk_pkg::in_beat_t in_beat,
    input  logic [31:0]       dir_x,
    input  logic [31:0]       dir_y,
    input  logic [31:0]       dir_z,
    input  logic [31:0]       min_distance,
    input  logic [31:0]       inv_bin_range,
    output sdsk_pkg::side_t   side_out,
    output logic [31:0]       depth_out
);
    import sdsk_pkg::*;

    side_t       side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;
    side_t       side1_next;
    logic [31:0] px_reg, py_reg, pz_reg, pz2_reg;
    logic [31:0] s_reg, t_reg, u_reg, d_reg;

    always_comb begin
        side1_next.valid         = in_valid;
        side1_next.action        = in_beat.action;
        side1_next.last_point    = in_beat.last_point;
        side1_next.table_index   = in_beat.table_index;
        side1_next.entry_base    = in_beat.entry_base;
        side1_next.entry_divider = in_beat.entry_divider;
    end

    // Only the valid bits are reset; the payload simply follows them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side1_reg.valid <= 1'b0;
            side2_reg.valid <= 1'b0;
            side3_reg.valid <= 1'b0;
            side4_reg.valid <= 1'b0;
            side5_reg.valid <= 1'b0;
        end else if (en) begin
            side1_reg.valid <= side1_next.valid;
            side2_reg.valid <= side1_reg.valid;
            side3_reg.valid <= side2_reg.valid;
            side4_reg.valid <= side3_reg.valid;
            side5_reg.valid <= side4_reg.valid;
        end
        if (en) begin
            side1_reg[$bits(side_t)-2:0] <= side1_next[$bits(side_t)-2:0];
            side2_reg[$bits(side_t)-2:0] <= side1_reg[$bits(side_t)-2:0];
            side3_reg[$bits(side_t)-2:0] <= side2_reg[$bits(side_t)-2:0];
            side4_reg[$bits(side_t)-2:0] <= side3_reg[$bits(side_t)-2:0];
            side5_reg[$bits(side_t)-2:0] <= side4_reg[$bits(side_t)-2:0];
            px_reg  <= fp_mul(in_beat.center_x, dir_x);
            py_reg  <= fp_mul(in_beat.center_y, dir_y);
            pz_reg  <= fp_mul(in_beat.center_z, dir_z);
            s_reg   <= fp_add(px_reg, py_reg);
            pz2_reg <= pz_reg;
            t_reg   <= fp_add(s_reg, pz2_reg);
            u_reg   <= fp_add(t_reg, {~min_distance[31], min_distance[30:0]});
            d_reg   <= fp_mul(u_reg, inv_bin_range);
        end
    end

    assign side_out  = side5_reg;
    assign depth_out = d_reg;

endmodule

// File: rtl/core/sdsk_key.sv
// ----------------------------------------------------------------------------
// sdsk_key
// Five stage key datapath: clamp and bin, fraction, bin table access,
// offset product, and the saturating key sum into the output register.
// ----------------------------------------------------------------------------
module sdsk_key #(
    parameter int unsigned BINS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  sdsk_pkg::side_t    side_in,
    input  logic [31:0]        depth_in,
    input  logic [31:0]        bucket_count,
    output logic               out_valid,
    output sdsk_pkg::out_beat_t out_beat
);
    import sdsk_pkg::*;

    localparam int unsigned BW = (BINS > 1) ? $clog2(BINS) : 1;
    localparam logic [31:0] TOP_BITS = uint_to_fp(24'(BINS));

    side_t       side6_reg, side7_reg;
    logic        v8_reg, v9_reg, v10_reg;
    logic        act8_reg, act9_reg;
    logic        last8_reg, last9_reg;
    logic [31:0] dc_reg, binf_reg, frac_reg, frac8_reg, divf_reg, prod_reg;
    logic [BW-1:0] bin6_reg, bin7_reg;
    logic [30:0] base8_reg, base9_reg;
    logic [23:0] div8_reg, div9_reg;
    out_beat_t   out_reg;

    logic [30:0] base_table_reg [BINS];
    logic [23:0] div_table_reg  [BINS];

    logic [31:0] dc_next;
    logic [24:0] bin_full;
    logic [BW-1:0] bin_next;
    logic [24:0] offset;
    logic [31:0] sum;
    logic [31:0] limit;
    logic [31:0] key_next;

    // A NaN or negative depth is taken as zero, anything above the top bin
    // edge (infinity included) as the edge itself.
    always_comb begin
        if (depth_in[31] || fp_is_nan(depth_in)) begin
            dc_next = 32'd0;
        end else if (depth_in[30:0] > TOP_BITS[30:0]) begin
            dc_next = TOP_BITS;
        end else begin
            dc_next = depth_in;
        end
        bin_full = fp_to_uint(dc_next);
        bin_next = (bin_full > 25'(BINS - 1)) ? BW'(BINS - 1) : BW'(bin_full);
    end

    always_comb begin
        offset = fp_to_uint(prod_reg);
        sum    = {1'b0, base9_reg} + {7'd0, offset};
        limit  = bucket_count - 32'd1;
        key_next = sum;
        if (key_next > limit) key_next = limit;
        if (key_next > KEY_MAX) key_next = KEY_MAX;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side6_reg.valid <= 1'b0;
            side7_reg.valid <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end else if (en) begin
            side6_reg.valid <= side_in.valid;
            side7_reg.valid <= side6_reg.valid;
            v8_reg  <= side7_reg.valid;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg && (act9_reg == ACT_POINT);
        end
        if (en) begin
            side6_reg[$bits(side_t)-2:0] <= side_in[$bits(side_t)-2:0];
            side7_reg[$bits(side_t)-2:0] <= side6_reg[$bits(side_t)-2:0];
            dc_reg    <= dc_next;
            bin6_reg  <= bin_next;
            binf_reg  <= uint_to_fp(24'(bin_next));
            frac_reg  <= fp_add(dc_reg, {~binf_reg[31], binf_reg[30:0]});
            bin7_reg  <= bin6_reg;
            act8_reg  <= side7_reg.action;
            last8_reg <= side7_reg.last_point;
            frac8_reg <= frac_reg;
            base8_reg <= base_table_reg[bin7_reg];
            div8_reg  <= div_table_reg[bin7_reg];
            divf_reg  <= uint_to_fp(div_table_reg[bin7_reg]);
            act9_reg  <= act8_reg;
            last9_reg <= last8_reg;
            base9_reg <= base8_reg;
            div9_reg  <= div8_reg;
            prod_reg  <= fp_mul(divf_reg, frac8_reg);
            out_reg.sort_key <= key_next[30:0];
            out_reg.last_key <= last9_reg;
        end
    end

    // Table writes take effect in pipeline order, at the stage where points
    // read the table, so a point never sees a write that came after it.
    always_ff @(posedge aclk) begin
        if (en && side7_reg.valid && (side7_reg.action == ACT_TABLE) &&
            (11'(side7_reg.table_index) < 11'(BINS))) begin
            base_table_reg[BW'(side7_reg.table_index)] <= side7_reg.entry_base;
            div_table_reg[BW'(side7_reg.table_index)]  <= side7_reg.entry_divider;
        end
    end

    assign out_valid = v10_reg;
    assign out_beat  = out_reg;

    a_bin_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        side6_reg.valid |-> (32'(bin6_reg) < BINS))
        else $error("bin index beyond the table");

    a_offset_le_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (v9_reg && (act9_reg == ACT_POINT)) |-> (offset <= {1'b0, div9_reg}))
        else $error("offset exceeds the bin divider");

    a_table_no_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && v9_reg && (act9_reg == ACT_TABLE)) |=> !v10_reg)
        else $error("table write produced a key beat");

endmodule

// File: rtl/core/splat_depth_sort_key.sv
// Each accepted point beat yields one key beat on m_, in input order.
// Throughput: one beat per cycle; the ten register stages advance together
// and hold while a key beat waits on m_ready.
// Table-write beats travel the same pipeline and yield no key beat.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// registers; bin tables are not cleared and must be written before use.
// ----------------------------------------------------------------------------
// splat_depth_sort_key
// Depth sort key for one point: binary32 depth along the view direction,
// binned through a loadable base and divider table.
// ----------------------------------------------------------------------------
module splat_depth_sort_key #(
    parameter int unsigned BINS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sdsk_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sdsk_pkg::out_beat_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [sdsk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]         cfg_data
);
    import sdsk_pkg::*;

    logic        en;
    logic [31:0] dir_x_reg, dir_y_reg, dir_z_reg;
    logic [31:0] min_dist_reg, inv_range_reg, buckets_reg;
    side_t       side5;
    logic [31:0] depth5;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_x_reg     <= 32'd0;
            dir_y_reg     <= 32'd0;
            dir_z_reg     <= 32'd0;
            min_dist_reg  <= 32'd0;
            inv_range_reg <= 32'd0;
            buckets_reg   <= 32'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DIR_X:     dir_x_reg     <= cfg_data;
                CFG_DIR_Y:     dir_y_reg     <= cfg_data;
                CFG_DIR_Z:     dir_z_reg     <= cfg_data;
                CFG_MIN_DIST:  min_dist_reg  <= cfg_data;
                CFG_INV_RANGE: inv_range_reg <= cfg_data;
                CFG_BUCKETS:   buckets_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    sdsk_depth u_depth (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (s_valid),
        .in_beat       (s_data),
        .dir_x         (dir_x_reg),
        .dir_y         (dir_y_reg),
        .dir_z         (dir_z_reg),
        .min_distance  (min_dist_reg),
        .inv_bin_range (inv_range_reg),
        .side_out      (side5),
        .depth_out     (depth5)
    );

    sdsk_key #(.BINS(BINS)) u_key (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .side_in      (side5),
        .depth_in     (depth5),
        .bucket_count (buckets_reg),
        .out_valid    (m_valid),
        .out_beat     (m_data)
    );

endmodule

// File: tb/splat_depth_sort_key_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splat_depth_sort_key_tb
// Self-checking bench for the depth sort key block. Point and table-write
// beats are queued by a stimulus process, predicted on the fly by a bit-exact
// binary32 model of the key arithmetic, driven with random gaps and checked
// in order against the key beats collected under random back-pressure.
// ----------------------------------------------------------------------------
module splat_depth_sort_key_tb;
    import sdsk_pkg::*;

    localparam int          NBINS      = 32;
    localparam int          IN_W       = $bits(in_beat_t);
    localparam int          DRAIN_WAIT = 12;
    localparam int          WDOG_LIMIT = 5000;
    localparam logic [31:0] F_ONE      = 32'h3F80_0000;
    localparam logic [31:0] F_TOP      = 32'h4200_0000;
    localparam logic [31:0] F_NAN      = 32'h7FC0_0000;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_beat_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_beat_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          value;
    } reg_write_t;

    in_beat_t   beat_q[$];
    out_beat_t  key_q[$];
    reg_write_t reg_q[$];

    // Predictor copies of the registers and bin tables.
    logic [31:0] view_x, view_y, view_z, near_depth, depth_scale, buckets;
    logic [30:0] bin_base[NBINS];
    logic [23:0] bin_span[NBINS];

    int  mismatches = 0;
    int  quiet      = 0;
    int  s_gap      = 0;
    int  m_hold     = 0;
    bit  calm       = 1'b0;

    splat_depth_sort_key u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- binary32 arithmetic ----------------

    // Rounds mag * 2^scale to nearest even, subnormals and overflow included.
    function automatic logic [31:0] f32_round(input logic sgn, input logic [79:0] mag,
                                              input int scale);
        int          msb, lsb, e, bx;
        logic [79:0] q, low;
        logic        half, sticky;
        if (mag == 80'd0) return {sgn, 31'd0};
        msb = 0;
        for (int i = 0; i < 80; i++) if (mag[i]) msb = i;
        lsb = msb - 23;
        if (lsb < -149 - scale) lsb = -149 - scale;
        if (lsb <= 0) begin
            q = mag << (-lsb);
        end else if (lsb > 80) begin
            q = 80'd0;
        end else begin
            q      = mag >> lsb;
            half   = mag[lsb-1];
            low    = (80'd1 << (lsb - 1)) - 80'd1;
            sticky = |(mag & low);
            if (half && (sticky || q[0])) q = q + 80'd1;
        end
        e = lsb + scale;
        if (q[24]) begin
            q = q >> 1;
            e++;
        end
        if (q < 80'h80_0000) return {sgn, 8'd0, q[22:0]};
        bx = e + 150;
        if (bx >= 255) return {sgn, 8'hFF, 23'd0};
        return {sgn, bx[7:0], q[22:0]};
    endfunction

    function automatic bit f32_nan(input logic [31:0] a);
        return a[30:23] == 8'hFF && a[22:0] != 23'd0;
    endfunction

    function automatic bit f32_inf(input logic [31:0] a);
        return a[30:23] == 8'hFF && a[22:0] == 23'd0;
    endfunction

    function automatic logic [23:0] f32_mant(input logic [31:0] a);
        return {a[30:23] != 8'd0, a[22:0]};
    endfunction

    function automatic int f32_exp(input logic [31:0] a);
        return (a[30:23] == 8'd0) ? -149 : int'(a[30:23]) - 150;
    endfunction

    function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
        logic sgn;
        logic [79:0] p;
        sgn = a[31] ^ b[31];
        if (f32_nan(a) || f32_nan(b)) return F_NAN;
        if ((f32_inf(a) && b[30:0] == 0) || (f32_inf(b) && a[30:0] == 0)) return F_NAN;
        if (f32_inf(a) || f32_inf(b)) return {sgn, 8'hFF, 23'd0};
        if (a[30:0] == 0 || b[30:0] == 0) return {sgn, 31'd0};
        p = 80'(f32_mant(a)) * 80'(f32_mant(b));
        return f32_round(sgn, p, f32_exp(a) + f32_exp(b));
    endfunction

    function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x, y;
        logic [79:0] big, sml, sum;
        int          d;
        if (f32_nan(a) || f32_nan(b)) return F_NAN;
        if (f32_inf(a) && f32_inf(b)) return (a[31] != b[31]) ? F_NAN : a;
        if (f32_inf(a)) return a;
        if (f32_inf(b)) return b;
        if (a[30:0] >= b[30:0]) begin
            x = a;
            y = b;
        end else begin
            x = b;
            y = a;
        end
        d   = f32_exp(x) - f32_exp(y);
        big = 80'(f32_mant(x)) << 40;
        sml = 80'(f32_mant(y)) << 40;
        // Bits shifted out of the smaller operand collapse into a sticky bit.
        if (d > 63) begin
            sml = 80'(sml != 0);
        end else begin
            sml = (sml >> d) | 80'(|(sml & ((80'd1 << d) - 80'd1)));
        end
        sum = (x[31] ^ y[31]) ? big - sml : big + sml;
        if (sum == 80'd0) return {x[31] & y[31], 31'd0};
        return f32_round(x[31], sum, f32_exp(x) - 40);
    endfunction

    function automatic logic [31:0] f32_trunc(input logic [31:0] a);
        if (a[30:23] < 8'd127) return 32'd0;
        if (a[30:23] >= 8'd150) return 32'(f32_mant(a)) << (a[30:23] - 8'd150);
        return 32'(f32_mant(a)) >> (8'd150 - a[30:23]);
    endfunction

    // ---------------- key predictor ----------------

    function automatic logic [30:0] depth_key(input logic [31:0] x, input logic [31:0] y,
                                              input logic [31:0] z);
        logic [31:0] depth, frac, span;
        logic [31:0] bin, sum, limit;
        depth = f32_add(f32_add(f32_mul(x, view_x), f32_mul(y, view_y)), f32_mul(z, view_z));
        depth = f32_add(depth, near_depth ^ 32'h8000_0000);
        depth = f32_mul(depth, depth_scale);
        if (f32_nan(depth) || (depth[31] && depth[30:0] != 0)) depth = 32'd0;
        if (depth[30:0] > F_TOP[30:0]) depth = F_TOP;
        bin = f32_trunc(depth);
        if (bin > NBINS - 1) bin = NBINS - 1;
        frac  = f32_add(depth, f32_round(1'b1, 80'(bin), 0));
        span  = f32_round(1'b0, 80'(bin_span[bin[4:0]]), 0);
        sum   = 32'(bin_base[bin[4:0]]) + f32_trunc(f32_mul(span, frac));
        limit = buckets - 32'd1;
        if (sum > limit) sum = limit;
        if (sum > KEY_MAX) sum = KEY_MAX;
        return sum[30:0];
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic int gap_len();
        return ($urandom_range(9, 0) < 8) ? $urandom_range(2, 1) : $urandom_range(40, 10);
    endfunction

    function automatic logic [31:0] any_float();
        logic [31:0] picks[8] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                                   32'h7FC0_0001, 32'h0000_0001, 32'h007F_FFFF,
                                   32'h7F7F_FFFF};
        case ($urandom_range(9, 0))
            0: return $urandom;
            1: return picks[$urandom_range(7, 0)];
            default: return {$urandom_range(9, 0) < 2, 8'($urandom_range(132, 120)),
                             23'($urandom)};
        endcase
    endfunction

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic last);
        in_beat_t  b;
        out_beat_t k;
        b = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        b.action     = ACT_POINT;
        b.center_x   = x;
        b.center_y   = y;
        b.center_z   = z;
        b.last_point = last;
        k.sort_key   = depth_key(x, y, z);
        k.last_key   = last;
        beat_q.push_back(b);
        key_q.push_back(k);
    endtask

    task automatic send_entry(input logic [4:0] idx, input logic [30:0] base,
                              input logic [23:0] span);
        in_beat_t b;
        b = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        b.action        = ACT_TABLE;
        b.table_index   = idx;
        b.entry_base    = base;
        b.entry_divider = span;
        bin_base[idx]   = base;
        bin_span[idx]   = span;
        beat_q.push_back(b);
    endtask

    task automatic drain();
        while (beat_q.size() != 0 || s_valid || key_q.size() != 0 ||
               reg_q.size() != 0 || cfg_valid)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Registers change only once the pipeline has emptied.
    task automatic set_regs(input logic [31:0] vx, input logic [31:0] vy,
                            input logic [31:0] vz, input logic [31:0] near,
                            input logic [31:0] scale, input logic [31:0] count);
        drain();
        view_x = vx;
        view_y = vy;
        view_z = vz;
        near_depth = near;
        depth_scale = scale;
        buckets = count;
        reg_q.push_back('{CFG_DIR_X, vx});
        reg_q.push_back('{CFG_DIR_Y, vy});
        reg_q.push_back('{CFG_DIR_Z, vz});
        reg_q.push_back('{CFG_MIN_DIST, near});
        reg_q.push_back('{CFG_INV_RANGE, scale});
        reg_q.push_back('{CFG_BUCKETS, count});
        drain();
    endtask

    task automatic random_beats(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99, 0) < 12)
                send_entry(5'($urandom), 31'($urandom), 24'($urandom));
            else
                send_point(any_float(), any_float(), any_float(), 1'($urandom));
        end
    endtask

    function automatic logic [31:0] any_count();
        case ($urandom_range(5, 0))
            0: return 32'd1;
            1: return 32'd0;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(32'h10_0000, 1);
            default: return $urandom;
        endcase
    endfunction

    // ---------------- stimulus ----------------

    initial begin
        view_x = 0; view_y = 0; view_z = 0;
        near_depth = 0; depth_scale = 0; buckets = 32'd1;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        calm = 1'b1;
        set_regs(F_ONE, 32'd0, 32'd0, 32'd0, F_ONE, 32'h8000_0000);
        for (int i = 0; i < NBINS; i++) begin
            case (i)
                0:  send_entry(5'(i), 31'h7FFF_FFFF, 24'hFF_FFFF);
                1:  send_entry(5'(i), 31'd0, 24'd0);
                31: send_entry(5'(i), 31'h7FFF_0000, 24'hFF_FFFF);
                default: send_entry(5'(i), 31'($urandom), 24'($urandom));
            endcase
        end
        // Depths at and around the edges of the bin range, plus NaN and infinities.
        send_point(32'h0, 32'h0, 32'h0, 1'b0);
        send_point(32'h8000_0000, 32'h0, 32'h0, 1'b1);
        send_point(32'hBF80_0000, 32'h0, 32'h0, 1'b0);
        send_point(F_TOP, 32'h0, 32'h0, 1'b1);
        send_point(32'h4204_0000, 32'h0, 32'h0, 1'b0);
        send_point(32'h41FC_0000, 32'h0, 32'h0, 1'b0);
        send_point(32'h3F00_0000, 32'h0, 32'h0, 1'b1);
        send_point(32'h3FC0_0000, 32'h0, 32'h0, 1'b0);
        send_point(32'h7FC0_0000, 32'h0, 32'h0, 1'b0);
        send_point(32'h7F80_0000, 32'h0, 32'h0, 1'b1);
        send_point(32'hFF80_0000, 32'h0, 32'h0, 1'b0);
        send_point(32'h0000_0001, 32'h0, 32'h0, 1'b0);
        send_point(32'h3F80_0000, 32'h7F80_0000, 32'h0, 1'b1);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_point(32'h41F8_0000, 32'h0, 32'h0, 1'b0);
        calm = 1'b0;
        set_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
        random_beats(40);
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_beats(40);
        // An all-ones direction with a gentle scale keeps most depths inside the bins.
        set_regs(F_ONE, F_ONE, F_ONE, 32'hC000_0000, 32'h3E80_0000, 32'd0);
        random_beats(120);
        for (int ph = 0; ph < 6; ph++) begin
            calm = (ph == 2);
            set_regs(any_float(), any_float(), any_float(), any_float(), any_float(),
                     any_count());
            random_beats(110);
        end
        drain();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ---------------- driver ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_gap > 0) begin
                s_gap   <= s_gap - 1;
                s_valid <= 1'b0;
            end else if (beat_q.size() != 0) begin
                s_valid <= 1'b1;
                s_data  <= beat_q.pop_front();
                s_gap   <= (calm || $urandom_range(9, 0) > 2) ? 0 : gap_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else if (!cfg_valid || cfg_ready) begin
            if (reg_q.size() != 0) begin
                reg_write_t w;
                w = reg_q.pop_front();
                cfg_valid <= 1'b1;
                cfg_index <= w.index;
                cfg_data  <= w.value;
            end else begin
                cfg_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (key_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected key beat: key %h last %b",
                                 m_data.sort_key, m_data.last_key);
                end else begin
                    out_beat_t want;
                    want = key_q.pop_front();
                    if (m_data.sort_key !== want.sort_key ||
                        m_data.last_key !== want.last_key) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("key mismatch: expected %h/%b, got %h/%b",
                                     want.sort_key, want.last_key,
                                     m_data.sort_key, m_data.last_key);
                    end
                end
            end
            if (m_hold > 0) begin
                m_hold  <= m_hold - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(9, 0) < 2) m_hold <= gap_len();
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= WDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule

// File: splat_depth_sort_key.f
rtl/core/sdsk_pkg.sv
rtl/core/sdsk_depth.sv
rtl/core/sdsk_key.sv
rtl/core/splat_depth_sort_key.sv
tb/splat_depth_sort_key_tb.sv
